// File: design/tcss_pkg.sv
// ----------------------------------------------------------------------------
// tcss_pkg
// Shared constants and control/status types for the texture column step
// sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcss_pkg;

    // Rows in one texture column
    localparam int unsigned TEX_ROWS = 64;

    // Width of heights, counts and steps
    localparam int unsigned HW = 7;

    // Width of row numbers on the output
    localparam int unsigned RW = 6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture height, start TEX / height
        logic setup;      // split steps, start majority / (minority + 1)
        logic take_run;   // capture run and lead, clear row counters
        logic emit;       // write one row into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic height_ok;  // input height in 1..TEX
        logic div_done;   // divider result ready this cycle
        logic out_free;   // output register can take a row
        logic last_row;   // current row is the final one of the column
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/tcss_div.sv
// ----------------------------------------------------------------------------
// tcss_div
// Restoring serial divider, one quotient bit per cycle. Quotient and
// remainder are valid in the cycle that o_done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcss_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [tcss_pkg::HW-1:0]  i_dividend,
    input  wire logic [tcss_pkg::HW-1:0]  i_divisor,
    output logic                          o_done,
    output logic [tcss_pkg::HW-1:0]       o_quotient,
    output logic [tcss_pkg::HW-1:0]       o_remainder
);
    import tcss_pkg::*;

    localparam int unsigned CW = $clog2(HW);

    logic [HW-1:0] r_rem, n_rem;
    logic [HW-1:0] r_quo, n_quo;
    logic [HW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [HW:0]   trial;
    logic          fits;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_quo[HW-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? HW'(trial - {1'b0, r_div}) : trial[HW-1:0];
        n_quo = {r_quo[HW-2:0], fits};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // Remainder is always reduced below the divisor at the end
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: design/tcss_dp.sv
// ----------------------------------------------------------------------------
// tcss_dp
// Datapath: step split, run/lead setup through the serial divider, and the
// per-row step selection feeding the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcss_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tcss_pkg::t_ctrl_cmd      i_cmd,
    output tcss_pkg::t_dp_status          o_sts,
    input  wire logic [tcss_pkg::HW-1:0]  i_column_height,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [tcss_pkg::RW-1:0]       o_source_row,
    output logic [tcss_pkg::RW-1:0]       o_row_index,
    output logic [tcss_pkg::HW-1:0]       o_step,
    output logic                          o_last
);
    import tcss_pkg::*;

    // Column setup registers
    logic [HW-1:0] r_height;
    logic [HW-1:0] r_small;
    logic          r_equal;
    logic [HW-1:0] r_min_step, r_maj_step;
    logic [HW-1:0] r_min_cnt;
    logic [HW-1:0] r_run, r_lead;

    // Row walk registers
    logic [HW-1:0] r_k;
    logic [HW-1:0] r_sum;
    logic [HW-1:0] r_placed;
    logic [HW-1:0] r_phase;

    // Output register
    logic          r_out_valid;
    logic [RW-1:0] r_source_row;
    logic [RW-1:0] r_row_index;
    logic [HW-1:0] r_step;
    logic          r_last;

    // Divider hookup
    logic          div_start;
    logic [HW-1:0] div_dividend, div_divisor;
    logic          div_done;
    logic [HW-1:0] div_quo, div_rem;

    // Setup terms from the first division
    logic [HW-1:0] nsmall;
    logic          big_minor;
    logic [HW-1:0] min_cnt_c, maj_cnt_c;
    logic [HW-1:0] big_c;

    // Row terms
    logic [HW-1:0] st;
    logic          take_min;
    logic          past_lead;
    logic          fits_run;
    logic          last_row;
    logic          out_free;

    // Step split: quotient is the small step, remainder the big-step count
    always_comb begin
        nsmall    = r_height - div_rem;
        big_minor = (div_rem < nsmall);
        min_cnt_c = big_minor ? div_rem : nsmall;
        maj_cnt_c = big_minor ? nsmall : div_rem;
        big_c     = div_quo + 1'b1;
    end

    // Divider operand select
    always_comb begin
        div_start    = i_cmd.load | i_cmd.setup;
        div_dividend = i_cmd.load ? HW'(TEX_ROWS) : maj_cnt_c;
        div_divisor  = i_cmd.load ? i_column_height : HW'(min_cnt_c + 1'b1);
    end

    tcss_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Step for the current row
    always_comb begin
        past_lead = (r_k >= r_lead);
        fits_run  = (({1'b0, r_k} + {1'b0, r_run}) < {1'b0, r_height});
        take_min  = 1'b0;
        if (r_equal) begin
            st = r_k[0] ? r_small : HW'(r_small + 1'b1);
        end else if (!past_lead) begin
            st = r_maj_step;
        end else if (fits_run && (r_phase == '0) && (r_placed < r_min_cnt)) begin
            st       = r_min_step;
            take_min = 1'b1;
        end else begin
            st = r_maj_step;
        end
        last_row = (HW'(r_k + 1'b1) == r_height);
        out_free = !r_out_valid || !i_out_stall;
    end

    // Setup and row-walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height   <= '0;
            r_small    <= '0;
            r_equal    <= 1'b0;
            r_min_step <= '0;
            r_maj_step <= '0;
            r_min_cnt  <= '0;
            r_run      <= '0;
            r_lead     <= '0;
            r_k        <= '0;
            r_sum      <= '0;
            r_placed   <= '0;
            r_phase    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_height <= i_column_height;
            end
            if (i_cmd.setup) begin
                r_small    <= div_quo;
                r_equal    <= (div_rem == nsmall);
                r_min_cnt  <= min_cnt_c;
                r_min_step <= big_minor ? big_c : div_quo;
                r_maj_step <= big_minor ? div_quo : big_c;
            end
            if (i_cmd.take_run) begin
                r_run    <= div_quo;
                // Half the leftover majority steps go first
                r_lead   <= div_rem >> 1;
                r_k      <= '0;
                r_sum    <= '0;
                r_placed <= '0;
                r_phase  <= (div_quo == '0) ? HW'(0) : HW'(1);
            end else if (i_cmd.emit) begin
                r_k   <= r_k + 1'b1;
                r_sum <= r_sum + st;
                if (take_min) begin
                    r_placed <= r_placed + 1'b1;
                end
                // Phase counts rows mod (run + 1) once past the lead
                if (past_lead) begin
                    r_phase <= (r_phase == r_run) ? HW'(0) : HW'(r_phase + 1'b1);
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_source_row <= r_sum[RW-1:0];
            r_row_index  <= r_k[RW-1:0];
            r_step       <= st;
            r_last       <= last_row;
        end
    end

    always_comb begin
        o_sts.height_ok = (i_column_height != '0) && (i_column_height <= HW'(TEX_ROWS));
        o_sts.div_done  = div_done;
        o_sts.out_free  = out_free;
        o_sts.last_row  = last_row;
    end

    assign o_out_valid  = r_out_valid;
    assign o_source_row = r_source_row;
    assign o_row_index  = r_row_index;
    assign o_step       = r_step;
    assign o_last       = r_last;

    // Minority steps never exceed their count while rows are written
    a_placed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_placed <= r_min_cnt))
        else $error("more minority steps placed than exist");

    // The steps of a column add up to the texture height
    a_sum_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && last_row) |-> (HW'(r_sum + st) == HW'(TEX_ROWS)))
        else $error("column steps do not cover the texture");

    // A row is never written over a stalled result
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("row written over a stalled result");

endmodule

`default_nettype wire

// File: design/tcss_ctrl.sv
// ----------------------------------------------------------------------------
// tcss_ctrl
// Controller: sequences the two divisions and the per-row emission of one
// column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcss_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire tcss_pkg::t_dp_status  i_sts,
    output tcss_pkg::t_ctrl_cmd        o_cmd
);
    import tcss_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV1 = 2'd1;
    localparam logic [1:0] S_DIV2 = 2'd2;
    localparam logic [1:0] S_ROWS = 2'd3;

    logic [1:0] r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // Heights outside 1..TEX are taken and dropped
                if (i_in_valid && i_sts.height_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    o_cmd.take_run = 1'b1;
                    n_state        = S_ROWS;
                end
            end
            S_ROWS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_row) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: design/texture_column_step_sequencer.sv
// ----------------------------------------------------------------------------
// texture_column_step_sequencer
// Shrinks a 64-row texture column to a screen column height, giving one
// texel row per screen row with the final row marked.
// ----------------------------------------------------------------------------
// From acceptance until the next column can be taken, a column of height h
// (1..64) goes through two 7-bit serial divisions in one shared divider
// (texture height by h, then majority count by minority count plus one),
// then its rows leave one per cycle through a single output register,
// slowed only by stall on the output side. Heights of zero or above
// 64 are accepted and give no rows. Steps across a column always total 64.
`timescale 1ns / 1ps
`default_nettype none

module texture_column_step_sequencer (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [tcss_pkg::HW-1:0]  i_column_height,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [tcss_pkg::RW-1:0]       o_source_row,
    output logic [tcss_pkg::RW-1:0]       o_row_index,
    output logic [tcss_pkg::HW-1:0]       o_step,
    output logic                          o_last
);
    import tcss_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    tcss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_column_height (i_column_height),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_source_row    (o_source_row),
        .o_row_index     (o_row_index),
        .o_step          (o_step),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// File: tb/texture_column_step_sequencer_tb.sv
// ----------------------------------------------------------------------------
// texture_column_step_sequencer_tb
// Drives column heights into the sequencer and checks every texel row it
// gives against an in-bench model of the step spreading. Directed heights
// cover the extremes and both minority cases. Random heights, idle gaps on
// both sides, a long output hold and a full drain exercise the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module texture_column_step_sequencer_tb;

    import tcss_pkg::*;

    localparam int LONG_HOLD      = 300;  // output hold, in cycles
    localparam int RANDOM_COLUMNS = 480;  // random columns that give rows
    localparam int END_SETTLE     = 100;  // cycles after the last row

    // One row as seen on the output side
    typedef struct packed {
        logic [RW-1:0] source_row;
        logic [RW-1:0] row_index;
        logic [HW-1:0] step;
        logic          last;
    } t_texel_row;

    // Expected texel rows and the check of what comes out
    class texel_row_scoreboard;
        t_texel_row  pending_rows[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return pending_rows.size();
        endfunction

        // Work out the rows of one accepted column
        function void expand_column(logic [HW-1:0] height);
            int            h, small_step, big_step, n_big, n_small;
            int            min_step, maj_step, min_cnt, maj_cnt;
            int            run_len, lead, placed, st;
            bit            alternate;
            logic [HW-1:0] texel_acc;
            t_texel_row    r;
            h = height;
            if (h == 0 || h > TEX_ROWS) return;
            small_step = TEX_ROWS / h;
            big_step   = small_step + 1;
            n_big      = TEX_ROWS % h;
            n_small    = h - n_big;
            alternate  = (n_big == n_small);
            if (n_big < n_small) begin
                min_step = big_step;   min_cnt = n_big;
                maj_step = small_step; maj_cnt = n_small;
            end else begin
                min_step = small_step; min_cnt = n_small;
                maj_step = big_step;   maj_cnt = n_big;
            end
            run_len   = maj_cnt / (min_cnt + 1);
            lead      = (maj_cnt - (min_cnt + 1) * run_len) / 2;
            placed    = 0;
            texel_acc = '0;
            for (int k = 0; k < h; k++) begin
                if (alternate) begin
                    st = (k % 2 == 0) ? big_step : small_step;
                end else if (k < lead) begin
                    st = maj_step;
                end else if (k + run_len < h && ((k - lead + 1) % (run_len + 1)) == 0
                             && placed < min_cnt) begin
                    st = min_step;
                    placed++;
                end else begin
                    st = maj_step;
                end
                r.source_row = texel_acc[RW-1:0];
                r.row_index  = RW'(k);
                r.step       = HW'(st);
                r.last       = (k == h - 1);
                pending_rows.push_back(r);
                texel_acc = texel_acc + HW'(st);
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        // Compare one accepted row with the oldest expected row
        function void check_row(t_texel_row got);
            t_texel_row want;
            if (pending_rows.size() == 0) begin
                flag($sformatf("row with nothing pending: src=%0d idx=%0d step=%0d last=%0d",
                               got.source_row, got.row_index, got.step, got.last));
                return;
            end
            want = pending_rows.pop_front();
            if (got.source_row !== want.source_row || got.row_index !== want.row_index ||
                got.step !== want.step || got.last !== want.last) begin
                flag($sformatf("src %0d/%0d idx %0d/%0d step %0d/%0d last %0d/%0d (exp/act)",
                               want.source_row, got.source_row, want.row_index,
                               got.row_index, want.step, got.step, want.last, got.last));
            end
        endfunction
    endclass

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          i_in_valid      = 1'b0;
    logic [HW-1:0] i_column_height = '0;
    logic          i_out_stall     = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [RW-1:0] o_source_row;
    logic [RW-1:0] o_row_index;
    logic [HW-1:0] o_step;
    logic          o_last;

    logic          hold_req     = 1'b0;
    logic          hold_on      = 1'b0;
    int            in_idle_max  = 17;
    int            out_idle_max = 17;
    int            row_wait     = 0;

    texel_row_scoreboard rows_sb = new();

    logic [HW-1:0] directed_heights[$] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd63, 7'd65, 7'd127, 7'd32, 7'd33, 7'd43,
        7'd21, 7'd5, 7'd7, 7'd48, 7'd17, 7'd31, 7'd60, 7'd96, 7'd10, 7'd1, 7'd64
    };

    texture_column_step_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_column_height (i_column_height),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_source_row    (o_source_row),
        .o_row_index     (o_row_index),
        .o_step          (o_step),
        .o_last          (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side: check each row, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_wait = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                rows_sb.check_row(t_texel_row'{o_source_row, o_row_index, o_step, o_last});
                row_wait = $urandom_range(0, out_idle_max);
            end
            if (hold_on) begin
                i_out_stall <= 1'b1;
            end else if (row_wait > 0) begin
                i_out_stall <= 1'b1;
                row_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Long output hold, so the block backs up and stalls its input
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Offer one column after a drawn idle gap; returns at acceptance
    task automatic send_column(input logic [HW-1:0] height);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_column_height <= height;
        do @(posedge i_clk); while (o_in_stall);
        rows_sb.expand_column(height);
    endtask

    // Limit on the whole run
    initial begin
        #20_000_000;
        $display("** texture_column_step_sequencer: FAILED **");
        $finish;
    end

    // Stimulus
    initial begin
        int            counted;
        int            pick;
        logic [HW-1:0] height;
        counted = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed heights: extremes, both minority kinds, out-of-range
        foreach (directed_heights[i]) send_column(directed_heights[i]);

        // random columns, idling mode changed every 40 transactions
        for (int n = 0; counted < RANDOM_COLUMNS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin in_idle_max = 17; out_idle_max <= 17; end
                    1: begin in_idle_max = 0;  out_idle_max <= 17; end
                    2: begin in_idle_max = 17; out_idle_max <= 0;  end
                    default: begin in_idle_max = 0; out_idle_max <= 0; end
                endcase
            end
            if (n == 150) begin
                hold_req    <= 1'b1;
                in_idle_max = 0;
            end
            if (n == 300) begin
                // sender goes quiet until every expected row is out
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (rows_sb.pending() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)      height = '0;
            else if (pick == 1) height = HW'($urandom_range(65, 127));
            else if (pick == 2) height = $urandom_range(0, 1) ? HW'(64) : HW'(1);
            else                height = HW'($urandom_range(1, 64));
            if (height != 0 && height <= TEX_ROWS) counted++;
            send_column(height);
        end
        i_in_valid <= 1'b0;

        // drain, then let the block settle
        while (rows_sb.pending() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (rows_sb.mismatches == 0 && rows_sb.pending() == 0) begin
            $display("** texture_column_step_sequencer: PASSED **");
        end else begin
            $display("** texture_column_step_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
